// File: rtl/core/bfks_pkg.sv
// Shared types and codes for the bounded FIFO with key search.
// No dependencies; imported by bounded_fifo_with_key_search.
`timescale 1ns / 1ps

package bfks_pkg;

   localparam int CODE_W  = 32;
   localparam int LABEL_W = 64;

   typedef enum logic [1:0] {
      OP_ENQUEUE = 2'd0,
      OP_DEQUEUE = 2'd1,
      OP_SEARCH  = 2'd2,
      OP_LIST    = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      STATUS_DONE      = 3'd0,
      STATUS_OVERFLOW  = 3'd1,
      STATUS_UNDERFLOW = 3'd2,
      STATUS_EMPTY     = 3'd3,
      STATUS_NOT_FOUND = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE = 2'd0,
      FSM_EXEC = 2'd1,
      FSM_WALK = 2'd2
   } fsm_type;

endpackage

// File: rtl/core/bounded_fifo_with_key_search.sv
// Bounded FIFO of code/label records with search by code and full listing.
// Depends on bfks_pkg for operation, status and sequencer state codes.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | operation, key_code, label_in
//  rsp     | out       | rsp_valid/rsp_stall  | status, code_out, label_out, last
//
// Enqueue and dequeue complete in the EXEC state. Search and list then walk
// the queue in the WALK state: one comparator steps through the record memory,
// one slot per cycle while rsp_stall is low, through its registered read port.
// A list transaction delivers one result per cycle while rsp_stall is low;
// rsp_stall high holds the sequencer on the pending record.
// Synchronous reset empties the queue; no clearing pass is needed.
`timescale 1ns / 1ps

module bounded_fifo_with_key_search
   import bfks_pkg::*;
#(
   parameter int DEPTH      = 10,
   parameter int LABEL_BITS = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_operation,
   input  logic signed [CODE_W-1:0]  req_key_code,
   input  logic [LABEL_W-1:0]        req_label_in,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [2:0]                rsp_status,
   output logic signed [CODE_W-1:0]  rsp_code_out,
   output logic [LABEL_W-1:0]        rsp_label_out,
   output logic                      rsp_last
);

   localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(DEPTH);

   logic signed [CODE_W-1:0] code_mem [DEPTH];
   logic [LABEL_BITS-1:0]    label_mem [DEPTH];

   fsm_type state_ff, state_in;

   op_type                   op_ff;
   logic signed [CODE_W-1:0] key_ff;
   logic [LABEL_BITS-1:0]    label_ff;

   logic [SLOT_W-1:0] head_ff, head_in;
   logic [SLOT_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [SLOT_W-1:0] walk_slot_ff, walk_slot_in;
   logic [CNT_W-1:0]  walk_idx_ff, walk_idx_in;

   logic signed [CODE_W-1:0] code_rd_ff;
   logic [LABEL_BITS-1:0]    label_rd_ff;

   logic                     out_valid_ff, out_valid_in;
   status_type               out_status_ff;
   logic signed [CODE_W-1:0] out_code_ff;
   logic [LABEL_W-1:0]       out_label_ff;
   logic                     out_last_ff;

   logic       accept;
   logic       out_free;
   logic       emit;
   status_type emit_status;
   logic       emit_data;
   logic       emit_last;
   logic       mem_write;
   logic       walk_end;
   logic       match;

   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
      next_slot = (s == LAST_SLOT) ? '0 : s + 1'b1;
   endfunction

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != FSM_IDLE);
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign walk_end  = ((walk_idx_ff + 1'b1) == count_ff);
   assign match     = (code_rd_ff == key_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_IDLE: begin
            if (accept) state_in = FSM_EXEC;
         end
         FSM_EXEC: begin
            if (out_free) begin
               if ((op_ff == OP_SEARCH || op_ff == OP_LIST) && count_ff != '0) begin
                  state_in = FSM_WALK;
               end else begin
                  state_in = FSM_IDLE;
               end
            end
         end
         FSM_WALK: begin
            if (out_free && (walk_end || (op_ff == OP_SEARCH && match))) begin
               state_in = FSM_IDLE;
            end
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   always_comb begin
      emit         = 1'b0;
      emit_status  = STATUS_DONE;
      emit_data    = 1'b0;
      emit_last    = 1'b1;
      mem_write    = 1'b0;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      walk_slot_in = walk_slot_ff;
      walk_idx_in  = walk_idx_ff;
      unique case (state_ff)
         FSM_IDLE: begin
         end
         FSM_EXEC: begin
            walk_slot_in = head_ff;
            walk_idx_in  = '0;
            if (out_free) begin
               unique case (op_ff)
                  OP_ENQUEUE: begin
                     emit = 1'b1;
                     if (count_ff == FULL_CNT) begin
                        emit_status = STATUS_OVERFLOW;
                     end else begin
                        mem_write = 1'b1;
                        tail_in   = next_slot(tail_ff);
                        count_in  = count_ff + 1'b1;
                     end
                  end
                  OP_DEQUEUE: begin
                     emit = 1'b1;
                     if (count_ff == '0) begin
                        emit_status = STATUS_UNDERFLOW;
                     end else begin
                        head_in  = next_slot(head_ff);
                        count_in = count_ff - 1'b1;
                     end
                  end
                  default: begin
                     if (count_ff == '0) begin
                        emit        = 1'b1;
                        emit_status = STATUS_EMPTY;
                     end
                  end
               endcase
            end
         end
         FSM_WALK: begin
            if (out_free) begin
               if (op_ff == OP_LIST) begin
                  emit      = 1'b1;
                  emit_data = 1'b1;
                  emit_last = walk_end;
               end else if (match) begin
                  emit      = 1'b1;
                  emit_data = 1'b1;
               end else if (walk_end) begin
                  emit        = 1'b1;
                  emit_status = STATUS_NOT_FOUND;
               end
               if (!walk_end && !(op_ff == OP_SEARCH && match)) begin
                  walk_slot_in = next_slot(walk_slot_ff);
                  walk_idx_in  = walk_idx_ff + 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign out_valid_in = emit || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_slot_ff <= walk_slot_in;
      walk_idx_ff  <= walk_idx_in;
      if (accept) begin
         op_ff    <= op_type'(req_operation);
         key_ff   <= req_key_code;
         label_ff <= req_label_in[LABEL_BITS-1:0];
      end
      if (emit) begin
         out_status_ff <= emit_status;
         out_code_ff   <= emit_data ? code_rd_ff : '0;
         out_label_ff  <= emit_data ? LABEL_W'(label_rd_ff) : '0;
         out_last_ff   <= emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_write) begin
         code_mem[tail_ff]  <= key_ff;
         label_mem[tail_ff] <= label_ff;
      end
      code_rd_ff  <= code_mem[walk_slot_in];
      label_rd_ff <= label_mem[walk_slot_in];
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_status    = out_status_ff;
   assign rsp_code_out  = out_code_ff;
   assign rsp_label_out = out_label_ff;
   assign rsp_last      = out_last_ff;

endmodule
